@@ rtl/lbs_pkg.sv @@
// Shared types and constants for the linear blend skinning engine.
package lbs_pkg;

    localparam int DefaultJointCount = 256;
    localparam int WordsPerJoint     = 12;
    localparam int AccWidth          = 48;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_INFL   = 2'd1,
        OP_EMPTY  = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       wr_en;
        logic       prod_en;
        logic [1:0] col;
        logic       sum_en;
        logic       weigh_en;
        logic [1:0] row;
        logic       acc_en;
        logic       acc_clear;
        logic       emit;
    } lbs_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       joint_ok;
        logic       elem_ok;
        logic       last;
        logic       out_busy;
    } lbs_status_t;

endpackage

@@ rtl/lbs_datapath.sv @@
// Datapath: matrix memory, row multiply-add, weighting, accumulators, output register.
module lbs_datapath #(
    parameter int JOINT_COUNT = lbs_pkg::DefaultJointCount
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lbs_pkg::lbs_cmd_t   cmd,
    output lbs_pkg::lbs_status_t status,
    input  logic                transform_mode,
    input  logic [1:0]          s_opcode,
    input  logic [7:0]          s_joint_index,
    input  logic [3:0]          s_element_index,
    input  logic signed [31:0]  s_matrix_word,
    input  logic [16:0]         s_weight,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [31:0]  s_pos_z,
    input  logic                s_last_influence,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_out_x,
    output logic signed [31:0]  m_out_y,
    output logic signed [31:0]  m_out_z,
    output logic                m_saturated
);
    import lbs_pkg::*;

    localparam int Depth = JOINT_COUNT * WordsPerJoint;
    localparam int AW    = $clog2(Depth);

    logic signed [31:0] mem [Depth];

    logic [1:0]          op_reg;
    logic [7:0]          joint_reg;
    logic [3:0]          elem_reg;
    logic signed [31:0]  word_reg;
    logic [16:0]         w_reg;
    logic signed [31:0]  p_reg [3];
    logic                last_reg;
    logic                mode_reg;
    logic [AW-1:0]       base_reg;
    logic [AW-1:0]       rd_addr;
    logic signed [31:0]  rd_reg [4];
    logic signed [63:0]  prod_reg [3];
    logic signed [49:0]  t_reg;
    logic signed [49:0]  t_next;
    logic signed [AccWidth+1:0] c_reg;
    logic signed [AccWidth-1:0] acc_reg [3];
    logic                clip_reg;
    logic                valid_reg;

    logic [AW+1:0]       base_full;
    logic signed [33:0]  hi;
    logic signed [33:0]  lo_prod;
    logic signed [AccWidth+1:0] sum;
    logic signed [AccWidth-1:0] acc_new;
    logic                acc_clip;
    logic                sat_any;
    logic signed [31:0]  cl [3];
    logic                cs [3];

    localparam logic signed [AccWidth+1:0] AccMax = {3'b000, {(AccWidth-1){1'b1}}};
    localparam logic signed [AccWidth+1:0] AccMin = {3'b111, {(AccWidth-1){1'b0}}};

    assign base_full = (AW+2)'(joint_reg) * (AW+2)'(WordsPerJoint);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_opcode;
            joint_reg <= s_joint_index;
            elem_reg  <= s_element_index;
            word_reg  <= s_matrix_word;
            w_reg     <= s_weight;
            p_reg[0]  <= s_pos_x;
            p_reg[1]  <= s_pos_y;
            p_reg[2]  <= s_pos_z;
            last_reg  <= s_last_influence;
            mode_reg  <= transform_mode;
        end
        base_reg <= base_full[AW-1:0];
    end

    assign status.opcode   = op_reg;
    assign status.joint_ok = (32'(joint_reg) < 32'(JOINT_COUNT));
    assign status.elem_ok  = (elem_reg < 4'(WordsPerJoint));
    assign status.last     = last_reg;
    assign status.out_busy = valid_reg;

    // One word is read per cycle; word address is row*4+col.
    assign rd_addr = base_reg + AW'({cmd.row, cmd.col});

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[base_full[AW-1:0] + AW'(elem_reg)] <= word_reg;
        end
        if (cmd.rd_en) begin
            rd_reg[cmd.col] <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prod_en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= 64'(rd_reg[i]) * 64'(p_reg[i]);
            end
        end
    end

    always_comb begin
        t_next = 50'(prod_reg[0] >>> 16) + 50'(prod_reg[1] >>> 16)
               + 50'(prod_reg[2] >>> 16);
        if (mode_reg) begin
            t_next = t_next + 50'(rd_reg[3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_en) begin
            t_reg <= t_next;
        end
    end

    assign hi      = 34'(t_reg >>> 16);
    assign lo_prod = $signed({1'b0, t_reg[15:0]}) * $signed({1'b0, w_reg});

    always_ff @(posedge aclk) begin
        if (cmd.weigh_en) begin
            c_reg <= (AccWidth+2)'(hi * $signed({1'b0, w_reg}))
                   + (AccWidth+2)'(lo_prod >>> 16);
        end
    end

    assign sum = (AccWidth+2)'(acc_reg[cmd.row]) + c_reg;
    always_comb begin
        acc_clip = 1'b0;
        acc_new  = sum[AccWidth-1:0];
        if (sum > AccMax) begin
            acc_new  = AccMax[AccWidth-1:0];
            acc_clip = 1'b1;
        end else if (sum < AccMin) begin
            acc_new  = AccMin[AccWidth-1:0];
            acc_clip = 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cs[i] = 1'b0;
            cl[i] = acc_reg[i][31:0];
            if (acc_reg[i] > AccWidth'(32'sh7fffffff)) begin
                cl[i] = 32'sh7fffffff;
                cs[i] = 1'b1;
            end else if (acc_reg[i] < -AccWidth'(64'sh80000000)) begin
                cl[i] = -32'sh80000000;
                cs[i] = 1'b1;
            end
        end
        sat_any = clip_reg | cs[0] | cs[1] | cs[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
            clip_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                valid_reg <= 1'b1;
                if (op_reg == OP_EMPTY) begin
                    m_out_x     <= '0;
                    m_out_y     <= '0;
                    m_out_z     <= '0;
                    m_saturated <= 1'b0;
                end else begin
                    m_out_x     <= cl[0];
                    m_out_y     <= cl[1];
                    m_out_z     <= cl[2];
                    m_saturated <= sat_any;
                end
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            if (cmd.acc_en) begin
                acc_reg[cmd.row] <= acc_new;
                if (acc_clip) begin
                    clip_reg <= 1'b1;
                end
            end
            if (cmd.acc_clear) begin
                for (int i = 0; i < 3; i++) begin
                    acc_reg[i] <= '0;
                end
                clip_reg <= 1'b0;
            end
        end
    end

    assign m_valid = valid_reg;

endmodule

@@ rtl/lbs_ctrl.sv @@
// Controller state machine sequencing loads, influences and emits.
module lbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lbs_pkg::lbs_status_t status,
    output lbs_pkg::lbs_cmd_t    cmd
);
    import lbs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_WEIGH,
        ST_ACC,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    logic [1:0] row_reg;
    logic [1:0] col_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.row      = row_reg;
        cmd.col      = col_reg;
        cmd.capture  = (state_reg == ST_IDLE) && s_valid;
        cmd.rd_en    = (state_reg == ST_READ);
        cmd.prod_en  = (state_reg == ST_MUL);
        cmd.sum_en   = (state_reg == ST_SUM);
        cmd.weigh_en = (state_reg == ST_WEIGH);
        cmd.acc_en   = (state_reg == ST_ACC);
        cmd.wr_en    = (state_reg == ST_DECODE) && (status.opcode == OP_LOAD)
                     && status.joint_ok && status.elem_ok;
        cmd.emit      = (state_reg == ST_EMIT) && !status.out_busy;
        cmd.acc_clear = cmd.emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    row_reg <= 2'd0;
                    col_reg <= 2'd0;
                    if (s_valid) begin
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    priority if (status.opcode == OP_EMPTY) begin
                        state_reg <= ST_EMIT;
                    end else if (status.opcode == OP_INFL && status.joint_ok) begin
                        state_reg <= ST_READ;
                    end else if (status.opcode == OP_INFL && status.last) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_READ: begin
                    col_reg <= col_reg + 2'd1;
                    if (col_reg == 2'd3) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:   state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_WEIGH;
                ST_WEIGH: state_reg <= ST_ACC;
                ST_ACC: begin
                    if (row_reg != 2'd2) begin
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= ST_READ;
                    end else if (status.last) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (!status.out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/linear_blend_skinning_top.sv @@
// Sequence: an influence runs three rows, each four single-word reads, multiply, sum,
// weigh and accumulate; a load writes one word; a last influence adds an emit step.
// Throughput: one request at a time; word-serial reads and the shared row datapath set it.
// The output register lets the next request start while a result waits.
// Reset (aresetn, synchronous) clears control, accumulators and mode (to 1);
// matrix memory is undefined until written.
module linear_blend_skinning_top #(
    parameter int JOINT_COUNT = lbs_pkg::DefaultJointCount
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [7:0]          s_joint_index,
    input  logic [3:0]          s_element_index,
    input  logic signed [31:0]  s_matrix_word,
    input  logic [16:0]         s_weight,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [31:0]  s_pos_z,
    input  logic                s_last_influence,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_out_x,
    output logic signed [31:0]  m_out_y,
    output logic signed [31:0]  m_out_z,
    output logic                m_saturated
);
    import lbs_pkg::*;

    logic        mode_reg;
    lbs_cmd_t    cmd;
    lbs_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    lbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lbs_datapath #(.JOINT_COUNT(JOINT_COUNT)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .transform_mode   (mode_reg),
        .s_opcode         (s_opcode),
        .s_joint_index    (s_joint_index),
        .s_element_index  (s_element_index),
        .s_matrix_word    (s_matrix_word),
        .s_weight         (s_weight),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_last_influence (s_last_influence),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_out_z          (m_out_z),
        .m_saturated      (m_saturated)
    );

`ifndef SYNTH
    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid) else $error("emit did not raise valid");
    a_no_emit_over_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !status.out_busy) else $error("result overwritten");
    a_write_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> !cmd.acc_en && !cmd.emit) else $error("write overlaps");
`endif

endmodule
